@@ rtl/core/bla_pkg.sv @@
// Shared types and constants for the button latch and auto-repeat block.
package bla_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_INITIAL_DELAY    = 2'd0;
	localparam logic [1:0] CFG_PRIMARY_PERIOD   = 2'd1;
	localparam logic [1:0] CFG_SECONDARY_PERIOD = 2'd2;

	// Configuration reset values
	localparam logic [7:0] RST_INITIAL_DELAY    = 8'd20;
	localparam logic [7:0] RST_PRIMARY_PERIOD   = 8'd4;
	localparam logic [7:0] RST_SECONDARY_PERIOD = 8'd8;

	// Filter constants
	localparam logic [15:0] DIR_MASK   = 16'hF000;
	localparam logic [15:0] MID_MASK   = 16'h0FF0;
	localparam logic [31:0] KEEP_MASK  = 32'hF00FF00F;
	localparam logic [3:0]  TIMER_MAX  = 4'd10;
	localparam logic [3:0]  TIMER_GATE = 4'd4;

	// Remainder unit: counter bits consumed per cycle
	localparam int RDX_BITS = 4;

	// Number of hold counters
	localparam int NUM_CNT = 8;

	// Controller to datapath commands
	typedef struct packed {
		logic       accept;   // input beat taken: filter and count
		logic       load;     // load remainder unit from counter load_sel
		logic       step;     // one digit of both remainders
		logic       eval;     // record masks for counter sel
		logic       emit;     // load output registers
		logic [2:0] sel;
		logic [2:0] load_sel;
	} bla_cmd_t;

	// Counter k serves button k (k < 4) or button k + 8 (k >= 4)
	function automatic logic [3:0] cnt_bit(input logic [2:0] k);
		return {k[2], k[2], k[1:0]};
	endfunction

endpackage

@@ rtl/core/button_latch_and_autorepeat.sv @@
// Top level of the button latch and auto-repeat block.
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   buttons[15:0]
//  out      source     out_valid / out_stall fresh_presses, primary_repeat, secondary_repeat
//  cfg      sink       cfg_we                cfg_index[1:0], cfg_data[7:0]
//
// The next beat is taken only after the result of the previous one has entered the output register.
// One shared remainder unit walks the eight hold counters, 4 bits a cycle.
// in_stall stays high from the accepted beat until the result enters the output register.
// A result waits in the output register under out_stall; the next beat is taken meanwhile,
// and its result then waits in the controller with in_stall held high.
// Reset restores the register defaults and clears latch, timer, history and counters.
module button_latch_and_autorepeat
	import bla_pkg::*;
#(
	parameter int HOLD_COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] buttons,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] fresh_presses,
	output logic [31:0] primary_repeat,
	output logic [31:0] secondary_repeat
);

	bla_cmd_t cmd;

	// Sequencer
	bla_ctrl #(
		.HOLD_COUNT_WIDTH(HOLD_COUNT_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Filter, counters and remainder unit
	bla_datapath #(
		.HOLD_COUNT_WIDTH(HOLD_COUNT_WIDTH)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.buttons          (buttons),
		.cmd              (cmd),
		.fresh_presses    (fresh_presses),
		.primary_repeat   (primary_repeat),
		.secondary_repeat (secondary_repeat)
	);

endmodule

@@ rtl/core/bla_ctrl.sv @@
// Controller state machine: sequences filtering, remainder digits and output.
module bla_ctrl
	import bla_pkg::*;
#(
	parameter int HOLD_COUNT_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output bla_cmd_t cmd
);

	localparam int NDIG  = (HOLD_COUNT_WIDTH + RDX_BITS - 1) / RDX_BITS;
	localparam int DIG_W = $clog2(NDIG);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_LOAD = 5'b00010,
		S_STEP = 5'b00100,
		S_EVAL = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	state_t             state_q, state_d;
	logic [2:0]         k_q, k_d;
	logic [DIG_W-1:0]   dig_q, dig_d;
	logic               out_valid_q, out_valid_d;
	logic               out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		k_d         = k_q;
		dig_d       = dig_q;
		out_valid_d = out_valid_q && out_stall;
		cmd         = '0;
		cmd.sel     = k_q;
		cmd.load_sel = k_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					k_d        = '0;
					state_d    = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				dig_d    = '0;
				state_d  = S_STEP;
			end
			S_STEP: begin
				cmd.step = 1'b1;
				dig_d    = dig_q + 1'b1;
				if (dig_q == DIG_W'(NDIG - 1)) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval     = 1'b1;
				cmd.load_sel = k_q + 3'd1;
				if (k_q == 3'(NUM_CNT - 1)) begin
					state_d = S_EMIT;
				end else begin
					cmd.load = 1'b1;
					k_d      = k_q + 3'd1;
					dig_d    = '0;
					state_d  = S_STEP;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.emit    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			dig_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			k_q         <= k_d;
			dig_q       <= dig_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

@@ rtl/core/bla_datapath.sv @@
// Datapath: config registers, button filter, hold counters, remainder unit, outputs.
module bla_datapath
	import bla_pkg::*;
#(
	parameter int HOLD_COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic [15:0] buttons,
	input  bla_cmd_t    cmd,
	output logic [15:0] fresh_presses,
	output logic [31:0] primary_repeat,
	output logic [31:0] secondary_repeat
);

	localparam int HCW  = HOLD_COUNT_WIDTH;
	localparam int NDIG = (HCW + RDX_BITS - 1) / RDX_BITS;
	localparam int PW   = NDIG * RDX_BITS;

	// Configuration
	logic [7:0] delay_raw_q, pper_raw_q, sper_raw_q;
	logic [6:0] delay, pper, sper;

	// Filter state
	logic [15:0] latched_q, prev_q;
	logic [3:0]  timer_q;
	logic [15:0] filt_q, fresh_q;
	logic [HCW-1:0] cnt_q [NUM_CNT];

	// Filter next values
	logic [15:0] held, cur, nxt_latched;
	logic [3:0]  nxt_timer, t;
	logic [4:0]  t_inc;

	// Remainder unit
	logic [PW-1:0]  sh_q;
	logic [6:0]     rp_q, rs_q;
	logic [7:0]     rp, rs;
	logic [HCW-1:0] c_q;

	// Per-item masks
	logic [15:0] clr_p_q, clr_s_q, flag_q;
	logic        ge_d, ge2, lt_d, lt_2d;
	logic [3:0]  bpos;
	logic [31:0] prim;

	// Halved registers; a zero half period acts as one
	assign delay = delay_raw_q[7:1];
	assign pper  = (pper_raw_q[7:1] == 7'd0) ? 7'd1 : pper_raw_q[7:1];
	assign sper  = (sper_raw_q[7:1] == 7'd0) ? 7'd1 : sper_raw_q[7:1];

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_raw_q <= RST_INITIAL_DELAY;
			pper_raw_q  <= RST_PRIMARY_PERIOD;
			sper_raw_q  <= RST_SECONDARY_PERIOD;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INITIAL_DELAY:    delay_raw_q <= cfg_data;
				CFG_PRIMARY_PERIOD:   pper_raw_q  <= cfg_data;
				CFG_SECONDARY_PERIOD: sper_raw_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Latch and activation timer filter
	always_comb begin
		held        = buttons & latched_q;
		cur         = buttons;
		nxt_latched = latched_q;
		nxt_timer   = timer_q;
		t           = timer_q;
		t_inc       = {1'b0, timer_q} + 5'd2;
		if (held != 16'd0) begin
			cur = held;
		end else if (buttons == 16'd0) begin
			nxt_latched = '0;
			nxt_timer   = (t_inc > {1'b0, TIMER_MAX}) ? TIMER_MAX : t_inc[3:0];
		end else begin
			if (t < TIMER_GATE && (buttons & DIR_MASK) != 16'd0) begin
				cur = buttons & DIR_MASK;
				t   = TIMER_MAX;
			end
			if (t >= TIMER_GATE) begin
				nxt_timer   = '0;
				cur         = cur & (~cur + 16'd1);
				nxt_latched = cur;
			end else begin
				cur         = '0;
				nxt_latched = '0;
				nxt_timer   = t;
			end
		end
	end

	// Filter state and hold counters, updated on the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q <= '0;
			timer_q   <= '0;
			prev_q    <= '0;
			for (int k = 0; k < NUM_CNT; k++) begin
				cnt_q[k] <= '0;
			end
		end else if (cmd.accept) begin
			latched_q <= nxt_latched;
			timer_q   <= nxt_timer;
			prev_q    <= cur;
			for (int k = 0; k < NUM_CNT; k++) begin
				cnt_q[k] <= cur[cnt_bit(3'(k))] ? cnt_q[k] + 1'b1 : '0;
			end
		end
	end

	// Filtered and fresh bits for this item
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			filt_q  <= cur;
			fresh_q <= cur & ~prev_q;
		end
	end

	// Remainder digit step: RDX_BITS restoring steps for both periods
	always_comb begin
		rp = {1'b0, rp_q};
		rs = {1'b0, rs_q};
		for (int i = 0; i < RDX_BITS; i++) begin
			rp = {rp[6:0], sh_q[PW-1-i]};
			if (rp >= {1'b0, pper}) begin
				rp = rp - {1'b0, pper};
			end
			rs = {rs[6:0], sh_q[PW-1-i]};
			if (rs >= {1'b0, sper}) begin
				rs = rs - {1'b0, sper};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sh_q <= PW'(cnt_q[cmd.load_sel]);
			c_q  <= cnt_q[cmd.load_sel];
			rp_q <= '0;
			rs_q <= '0;
		end else if (cmd.step) begin
			sh_q <= sh_q << RDX_BITS;
			rp_q <= rp[6:0];
			rs_q <= rs[6:0];
		end
	end

	// Threshold tests on the current counter; only the ge2 test reads a set top bit as negative
	assign ge_d  = c_q >= HCW'(delay);
	assign lt_d  = !ge_d;
	assign lt_2d = c_q < HCW'({delay, 1'b0});
	assign ge2   = !c_q[HCW-1] && (c_q >= HCW'(2));
	assign bpos  = cnt_bit(cmd.sel);

	// Clear and held-flag masks
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			clr_p_q <= '0;
			clr_s_q <= '0;
			flag_q  <= '0;
		end else if (cmd.eval) begin
			clr_p_q[bpos] <= (ge_d && rp_q != 7'd0) || (ge2 && lt_d);
			clr_s_q[bpos] <= (ge_d && rs_q != 7'd0) || (ge2 && lt_2d);
			flag_q[bpos]  <= ge_d;
		end
	end

	// Output registers
	assign prim = {flag_q, filt_q & ~clr_p_q};

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			fresh_presses    <= fresh_q;
			primary_repeat   <= (prim & KEEP_MASK) | {16'd0, fresh_q & MID_MASK};
			secondary_repeat <= ({16'd0, filt_q & ~clr_s_q} & KEEP_MASK)
				| {16'd0, fresh_q & MID_MASK};
		end
	end

endmodule
